### sv/bfl_pkg.sv
// ----------------------------------------------------------------------------
// bfl_pkg
// Shared types and codes for the byte FIFO with length-prefixed messages.
// ----------------------------------------------------------------------------
package bfl_pkg;

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_BEGIN    = 3'd3,
    OP_MSG_BYTE = 3'd4,
    OP_POP_MSG  = 3'd5,
    OP_PEEK_MSG = 3'd6,
    OP_NOP      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_TOOLONG = 3'd3,
    ST_SHORT   = 3'd4,
    ST_NOMSG   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_BODY_RD,
    S_BODY_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // latch the incoming item
    logic exec;     // evaluate the latched item and load its first result
    logic body;     // load one body byte result
    logic rd_en;    // capture memory read data this cycle
    logic rd_scan;  // read at the scan pointer instead of the read pointer
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic body_follow;  // message pop or peek succeeded with a nonempty body
    logic body_last;    // the body byte being emitted is the final one
  } sts_t;

endpackage

### sv/bfl_ctrl.sv
// ----------------------------------------------------------------------------
// bfl_ctrl
// Sequencer: accepts one item, runs its evaluation and steps through the
// body bytes of a message pop or peek.
// ----------------------------------------------------------------------------
module bfl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bfl_pkg::sts_t sts_i,
  output bfl_pkg::cmd_t cmd_o
);
  import bfl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.out_free) state_d = sts_i.body_follow ? S_BODY_RD : S_IDLE;
      end
      S_BODY_RD: begin
        state_d = S_BODY_OUT;
      end
      S_BODY_OUT: begin
        if (sts_i.out_free) state_d = sts_i.body_last ? S_IDLE : S_BODY_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        cmd_o.rd_en  = 1'b1;
      end
      S_EXEC: begin
        cmd_o.exec = sts_i.out_free;
      end
      S_BODY_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_scan = 1'b1;
      end
      S_BODY_OUT: begin
        cmd_o.body = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### sv/bfl_datapath.sv
// ----------------------------------------------------------------------------
// bfl_datapath
// Ring storage, pointers, counters, item evaluation and the output register.
// ----------------------------------------------------------------------------
module bfl_datapath #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned MAX_MESSAGE = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfl_pkg::cmd_t     cmd_i,
  output bfl_pkg::sts_t     sts_o,
  input  logic [2:0]        op_i,
  input  logic [7:0]        data_in_i,
  input  logic [7:0]        msg_len_i,
  input  logic [7:0]        dest_capacity_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bfl_pkg::status_e  status_o,
  output logic [7:0]        data_out_o,
  output logic [5:0]        length_out_o,
  output logic              last_o,
  output logic [8:0]        fill_level_o,
  output logic              is_empty_o
);
  import bfl_pkg::*;

  localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 9;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rd_data_q;
  logic [PW-1:0] rd_addr;

  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] scan_q, scan_d;
  logic [CW-1:0] count_q, count_d;
  logic [5:0]    pend_q, pend_d;
  logic [5:0]    remain_q, remain_d;

  op_e           op_q;
  logic [7:0]    din_q, mlen_q, cap_q;

  logic          wr_en;
  logic [7:0]    wr_data;
  status_e       ex_status;
  logic [7:0]    ex_data;
  logic [5:0]    ex_len;
  logic          ex_last;
  logic          ex_follow;
  logic [CW-1:0] ex_fill;

  logic [SW-1:0] count_ext, hdr_ext;
  logic          is_zero, is_full;

  assign rd_addr   = cmd_i.rd_scan ? scan_q : rd_ptr_q;
  assign count_ext = SW'(count_q);
  assign hdr_ext   = SW'(rd_data_q);
  assign is_zero   = (count_q == '0);
  assign is_full   = (count_q == CW'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= wr_data;
    if (cmd_i.rd_en) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_e'(op_i);
      din_q  <= data_in_i;
      mlen_q <= msg_len_i;
      cap_q  <= dest_capacity_i;
    end
  end

  // Evaluation of the latched item. The first result's fill level is the
  // count after the whole item, so a message pop reports its final count here.
  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    count_d   = count_q;
    pend_d    = pend_q;
    scan_d    = scan_q;
    remain_d  = remain_q;
    wr_en     = 1'b0;
    wr_data   = din_q;
    ex_status = ST_OK;
    ex_data   = '0;
    ex_len    = '0;
    ex_last   = 1'b1;
    ex_follow = 1'b0;
    case (op_q)
      OP_PUSH: begin
        if (is_full) begin
          ex_status = ST_FULL;
        end else begin
          wr_en    = cmd_i.exec;
          wr_ptr_d = ptr_inc(wr_ptr_q);
          count_d  = count_q + 1'b1;
        end
      end
      OP_POP: begin
        if (is_zero) begin
          ex_status = ST_EMPTY;
        end else begin
          ex_data  = rd_data_q;
          rd_ptr_d = ptr_inc(rd_ptr_q);
          count_d  = count_q - 1'b1;
        end
      end
      OP_PEEK: begin
        if (is_zero) ex_status = ST_EMPTY;
        else         ex_data   = rd_data_q;
      end
      OP_BEGIN: begin
        if (mlen_q > 8'(MAX_MESSAGE)) begin
          ex_status = ST_TOOLONG;
        end else if (count_ext + SW'(1) + SW'(mlen_q) > SW'(DEPTH)) begin
          ex_status = ST_FULL;
        end else begin
          wr_en    = cmd_i.exec;
          wr_data  = mlen_q;
          wr_ptr_d = ptr_inc(wr_ptr_q);
          count_d  = count_q + 1'b1;
          pend_d   = mlen_q[5:0];
        end
      end
      OP_MSG_BYTE: begin
        if (pend_q == '0) begin
          ex_status = ST_NOMSG;
        end else if (is_full) begin
          ex_status = ST_FULL;
        end else begin
          wr_en    = cmd_i.exec;
          wr_ptr_d = ptr_inc(wr_ptr_q);
          count_d  = count_q + 1'b1;
          pend_d   = pend_q - 1'b1;
        end
      end
      OP_POP_MSG, OP_PEEK_MSG: begin
        if (is_zero) begin
          ex_status = ST_EMPTY;
        end else begin
          // A message pop drops the header even when it fails.
          if (op_q == OP_POP_MSG) begin
            rd_ptr_d = ptr_inc(rd_ptr_q);
            count_d  = count_q - 1'b1;
          end
          if (rd_data_q > 8'(MAX_MESSAGE) || rd_data_q > cap_q) begin
            ex_status = ST_TOOLONG;
          end else if (hdr_ext > count_ext - SW'(1)) begin
            ex_status = ST_SHORT;
          end else begin
            ex_len    = rd_data_q[5:0];
            ex_last   = (rd_data_q == '0);
            ex_follow = (rd_data_q != '0);
            scan_d    = ptr_inc(rd_ptr_q);
            remain_d  = rd_data_q[5:0];
          end
        end
      end
      default: begin
        ex_status = ST_OK;
      end
    endcase
    ex_fill = count_d;
    if (op_q == OP_POP_MSG && ex_follow) begin
      ex_fill = CW'(count_ext - SW'(1) - hdr_ext);
    end
  end

  assign sts_o.out_free    = !out_valid_o || out_ready_i;
  assign sts_o.body_follow = ex_follow;
  assign sts_o.body_last   = (remain_q == 6'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      scan_q      <= '0;
      count_q     <= '0;
      pend_q      <= '0;
      remain_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        scan_q   <= scan_d;
        count_q  <= count_d;
        pend_q   <= pend_d;
        remain_q <= remain_d;
      end else if (cmd_i.body) begin
        scan_q   <= ptr_inc(scan_q);
        remain_q <= remain_q - 1'b1;
        if (op_q == OP_POP_MSG) begin
          rd_ptr_q <= ptr_inc(rd_ptr_q);
          count_q  <= count_q - 1'b1;
        end
      end
      if (cmd_i.exec || cmd_i.body) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Body results keep the fill level and empty flag of the header result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_o     <= ex_status;
      data_out_o   <= ex_data;
      length_out_o <= ex_len;
      last_o       <= ex_last;
      fill_level_o <= 9'(ex_fill);
      is_empty_o   <= (ex_fill == '0);
    end else if (cmd_i.body) begin
      status_o     <= ST_OK;
      data_out_o   <= rd_data_q;
      length_out_o <= '0;
      last_o       <= (remain_q == 6'd1);
    end
  end

endmodule

### sv/byte_fifo_with_length_prefixed_messages.sv
// Each item is latched, then evaluated into the output register; evaluation waits while
// the output register holds an untaken result. A new item is accepted only when idle.
// Message pop and peek: the header result comes first, then one result per body byte,
// each read through the single registered read port of the ring storage.
// Reset clears pointers, fill count and open-message count; storage is not cleared.
// ----------------------------------------------------------------------------
// byte_fifo_with_length_prefixed_messages
// Circular byte FIFO with byte push, pop and peek and length-prefixed message
// push, pop and peek, on stream-style input and output channels.
// ----------------------------------------------------------------------------
module byte_fifo_with_length_prefixed_messages #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned MAX_MESSAGE = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // data_in[7:0], msg_len[15:8], dest_capacity[23:16]
  input  logic [2:0]  s_axis_tuser,   // op[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // data_out[7:0], length_out[13:8], fill_level[22:14],
                                      // is_empty[23]
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  output logic        m_axis_tlast
);
  import bfl_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  status_e    status;
  logic [7:0] data_out;
  logic [5:0] length_out;
  logic [8:0] fill_level;
  logic       is_empty;

  bfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfl_datapath #(
    .DEPTH       (DEPTH),
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (s_axis_tuser),
    .data_in_i       (s_axis_tdata[7:0]),
    .msg_len_i       (s_axis_tdata[15:8]),
    .dest_capacity_i (s_axis_tdata[23:16]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .status_o        (status),
    .data_out_o      (data_out),
    .length_out_o    (length_out),
    .last_o          (m_axis_tlast),
    .fill_level_o    (fill_level),
    .is_empty_o      (is_empty)
  );

  assign m_axis_tdata = {is_empty, fill_level, length_out, data_out};
  assign m_axis_tuser = status;

endmodule
